[rtl/core/kwlex_pkg.sv]
package kwlex_pkg;

  localparam int TEXT_BYTES = 8;
  localparam int MAX_COUNT  = 255;

  localparam int TOKQ_DEPTH = 4;
  localparam int TOKQ_AW    = $clog2(TOKQ_DEPTH);

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;

  // "exit" and "let", first character in the low byte
  localparam logic [63:0] EXIT_PACKED = 64'h0000_0000_7469_7865;
  localparam logic [63:0] LET_PACKED  = 64'h0000_0000_0074_656C;

  typedef enum logic [3:0] {
    KIND_EXIT  = 4'd0,
    KIND_LET   = 4'd1,
    KIND_IDENT = 4'd2,
    KIND_INT   = 4'd3,
    KIND_OPEN  = 4'd4,
    KIND_CLOSE = 4'd5,
    KIND_SEMI  = 4'd6,
    KIND_EQ    = 4'd7,
    KIND_ERR   = 4'd8
  } kind_t;

  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_WORD = 4'b0010,
    MODE_NUM  = 4'b0100,
    MODE_HALT = 4'b1000
  } mode_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] text;
    logic [7:0]  length;
    logic        trunc;
    logic        last;
  } tok_t;

endpackage

[rtl/core/kwlex_scan.sv]
module kwlex_scan
  import kwlex_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] char_byte,
  input  logic       end_of_input,
  output tok_t       tok0,
  output tok_t       tok1,
  output logic [1:0] tok_n
);

  mode_t       mode, mode_next;
  logic [63:0] store, store_next;
  logic [7:0]  count, count_next;

  logic is_letter, is_digit, is_space, pending, extend;
  tok_t flush_tok, char_tok;
  logic has_char;

  assign is_letter = char_byte inside {[8'h61:8'h7A], [8'h41:8'h5A]};
  assign is_digit  = char_byte inside {[8'h30:8'h39]};
  assign is_space  = char_byte inside {8'h20, [8'h09:8'h0D]};
  assign pending   = (mode == MODE_WORD) || (mode == MODE_NUM);
  assign extend    = ((mode == MODE_WORD) && (is_letter || is_digit)) ||
                     ((mode == MODE_NUM) && is_digit);

  // token for the pending word or number
  always_comb begin
    flush_tok        = '0;
    flush_tok.text   = store;
    flush_tok.length = count;
    flush_tok.trunc  = count > 8'(TEXT_BYTES);
    if (mode == MODE_NUM) begin
      flush_tok.kind = KIND_INT;
    end else if (count == 8'd4 && store == EXIT_PACKED) begin
      flush_tok = '0;
      flush_tok.kind = KIND_EXIT;
    end else if (count == 8'd3 && store == LET_PACKED) begin
      flush_tok = '0;
      flush_tok.kind = KIND_LET;
    end else begin
      flush_tok.kind = KIND_IDENT;
    end
  end

  // token for a single-character byte
  always_comb begin
    char_tok = '0;
    has_char = 1'b1;
    case (char_byte)
      CH_OPEN:  char_tok.kind = KIND_OPEN;
      CH_CLOSE: char_tok.kind = KIND_CLOSE;
      CH_SEMI:  char_tok.kind = KIND_SEMI;
      CH_EQ:    char_tok.kind = KIND_EQ;
      default: begin
        char_tok.kind = KIND_ERR;
        has_char = !(is_letter || is_digit || is_space);
      end
    endcase
  end

  always_comb begin
    mode_next  = mode;
    store_next = store;
    count_next = count;
    tok0  = '0;
    tok1  = '0;
    tok_n = 2'd0;
    if (fire && mode != MODE_HALT) begin
      if (end_of_input) begin
        tok0       = flush_tok;
        tok0.last  = 1'b1;
        tok_n      = pending ? 2'd1 : 2'd0;
        mode_next  = MODE_IDLE;
        store_next = '0;
        count_next = '0;
      end else if (extend) begin
        for (int i = 0; i < TEXT_BYTES; i++) begin
          if (count == 8'(i)) store_next[8*i +: 8] = char_byte;
        end
        if (count < 8'(MAX_COUNT)) count_next = count + 8'd1;
      end else begin
        mode_next  = MODE_IDLE;
        store_next = '0;
        count_next = '0;
        if (is_letter || is_digit) begin
          mode_next  = is_letter ? MODE_WORD : MODE_NUM;
          store_next = 64'(char_byte);
          count_next = 8'd1;
        end else if (has_char && char_tok.kind == KIND_ERR) begin
          mode_next = MODE_HALT;
        end
        if (pending) begin
          tok0      = flush_tok;
          tok0.last = !has_char;
          tok1      = char_tok;
          tok1.last = 1'b1;
          tok_n     = has_char ? 2'd2 : 2'd1;
        end else begin
          tok0      = char_tok;
          tok0.last = 1'b1;
          tok_n     = has_char ? 2'd1 : 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_IDLE;
      store <= '0;
      count <= '0;
    end else begin
      mode  <= mode_next;
      store <= store_next;
      count <= count_next;
    end
  end

endmodule

[rtl/core/kwlex_tokq.sv]
module kwlex_tokq
  import kwlex_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_n,
  input  tok_t       push0,
  input  tok_t       push1,
  input  logic       pop,
  output tok_t       head,
  output logic       not_empty,
  output logic       room2
);

  tok_t mem [TOKQ_DEPTH];
  logic [TOKQ_AW-1:0] wr, rd;
  logic [TOKQ_AW:0]   count, count_next;
  logic               do_pop;

  assign not_empty  = count != '0;
  assign do_pop     = pop && not_empty;
  assign head       = mem[rd];
  assign room2      = count <= (TOKQ_AW+1)'(TOKQ_DEPTH - 2);
  assign count_next = count + (TOKQ_AW+1)'(push_n) - (TOKQ_AW+1)'(do_pop);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wr] <= push0;
    if (push_n == 2'd2) mem[wr + TOKQ_AW'(1)] <= push1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      wr    <= wr + TOKQ_AW'(push_n);
      rd    <= rd + TOKQ_AW'(do_pop);
      count <= count_next;
    end
  end

endmodule

[rtl/core/keyword_ident_number_lexer_unit.sv]
// Lexer for a small language: one ASCII byte per beat in, tokens out. Words
// become exit, let or identifier tokens, digit runs become integer literals,
// ( ) ; = become single tokens and whitespace is skipped. Identifier and literal
// text is packed first-character-in-low-byte, up to eight bytes, with a length
// that saturates at 255. A symbol or unknown byte that closes a pending word or
// number gives two tokens. An unknown byte gives an error token and halts the
// lexer until reset; end_of_input flushes the pending token. Rate: one byte per
// cycle while the output keeps up. A byte passes through the input register,
// then the four-entry token queue. The input stalls while the queue has fewer
// than two free entries.
module keyword_ident_number_lexer_unit
  import kwlex_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_byte,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  token_kind,
  output logic [63:0] token_text,
  output logic [7:0]  token_length,
  output logic        text_truncated,
  output logic        last
);

  logic       stg_valid;
  logic [7:0] stg_byte;
  logic       stg_eoi;
  logic       stg_fire, room2;
  tok_t       tok0, tok1, head;
  logic [1:0] tok_n;

  assign stg_fire = stg_valid && room2;
  assign in_ready = !stg_valid || room2;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stg_valid <= 1'b1;
    end else if (stg_fire) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_byte <= char_byte;
      stg_eoi  <= end_of_input;
    end
  end

  kwlex_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .fire         (stg_fire),
    .char_byte    (stg_byte),
    .end_of_input (stg_eoi),
    .tok0         (tok0),
    .tok1         (tok1),
    .tok_n        (tok_n)
  );

  kwlex_tokq u_tokq (
    .clk       (clk),
    .rst       (rst),
    .push_n    (tok_n),
    .push0     (tok0),
    .push1     (tok1),
    .pop       (out_ready),
    .head      (head),
    .not_empty (out_valid),
    .room2     (room2)
  );

  assign token_kind     = head.kind;
  assign token_text     = head.text;
  assign token_length   = head.length;
  assign text_truncated = head.trunc;
  assign last           = head.last;

endmodule

[rtl/core/kwlex_chk.sv]
module kwlex_chk
  import kwlex_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  char_byte,
  input logic        end_of_input,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  token_kind,
  input logic [63:0] token_text,
  input logic [7:0]  token_length,
  input logic        text_truncated,
  input logic        last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(token_kind) && $stable(token_text) &&
      $stable(token_length) && $stable(text_truncated) && $stable(last))
    else $error("output beat changed while stalled");

  // a keyword can be followed by a symbol from the same byte, so last is free here
  a_plain_tok: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind != KIND_IDENT && token_kind != KIND_INT |->
      token_text == '0 && token_length == '0 && !text_truncated)
    else $error("keyword or symbol token carries text");

  a_trunc_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && text_truncated |-> token_length > 8'(TEXT_BYTES))
    else $error("truncation flag on a short token");

  a_halt: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && token_kind == KIND_ERR |=> !out_valid)
    else $error("token after error");

endmodule

bind keyword_ident_number_lexer_unit kwlex_chk u_chk (.*);
